// File: design/knn_pkg.sv
// Shared constants, request codes and sequencer states of the kNN color classifier.
package knn_pkg;

	localparam int MAX_SAMPLES_DEF   = 1024;
	localparam int MAX_NEIGHBORS_DEF = 32;
	localparam int CHANNEL_BITS_DEF  = 16;

	localparam int FIELD_W = 16;
	localparam int REQ_W   = 2;
	localparam int CLASS_W = 2;
	localparam int CFG_W   = 6;

	localparam logic [REQ_W-1:0] REQ_LOAD     = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CLASSIFY = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR    = 2'd2;

	localparam logic [CLASS_W-1:0] CLASS_NONE    = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_SKIN    = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_NONSKIN = 2'd2;

	localparam logic [CFG_W-1:0] NEIGHBOR_RESET = 6'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_VOTE,
		ST_DONE
	} state_t;

endpackage

// File: design/knn_req_if.sv
// Request channel: valid/ready handshake carrying one request.
interface knn_req_if;
	logic                           valid;
	logic                           ready;
	logic [knn_pkg::REQ_W-1:0]      req_type;
	logic [knn_pkg::FIELD_W-1:0]    red;
	logic [knn_pkg::FIELD_W-1:0]    green;
	logic [knn_pkg::FIELD_W-1:0]    blue;
	logic                           skin_label;

	modport source (output valid, req_type, red, green, blue, skin_label, input ready);
	modport sink   (input valid, req_type, red, green, blue, skin_label, output ready);
endinterface

// File: design/knn_rsp_if.sv
// Result channel: valid/ready handshake carrying one result.
interface knn_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [knn_pkg::CLASS_W-1:0]   predicted_class;
	logic                          store_full;

	modport source (output valid, predicted_class, store_full, input ready);
	modport sink   (input valid, predicted_class, store_full, output ready);
endinterface

// File: design/knn_ram.sv
// Generic simple dual-port RAM with registered read.
module knn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
	input  logic [WIDTH-1:0]                  wdata,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
	output logic [WIDTH-1:0]                  rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: design/knn_dist.sv
// Pipelined squared Euclidean distance unit: abs diff, square, sum.
module knn_dist #(
	parameter int CHANNEL_BITS = knn_pkg::CHANNEL_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [CHANNEL_BITS-1:0]   s_red,
	input  logic [CHANNEL_BITS-1:0]   s_green,
	input  logic [CHANNEL_BITS-1:0]   s_blue,
	input  logic                      s_label,
	input  logic [CHANNEL_BITS-1:0]   q_red,
	input  logic [CHANNEL_BITS-1:0]   q_green,
	input  logic [CHANNEL_BITS-1:0]   q_blue,
	output logic                      out_valid,
	output logic [2*CHANNEL_BITS+1:0] sq_dist,
	output logic                      label,
	output logic                      busy
);
	localparam int CB = CHANNEL_BITS;
	localparam int SW = 2 * CB;

	logic          valid_s1, valid_s2, valid_s3;
	logic [CB-1:0] dr_s1, dg_s1, db_s1;
	logic [SW-1:0] sr_s2, sg_s2, sb_s2;
	logic [SW+1:0] sum_s3;
	logic          lbl_s1, lbl_s2, lbl_s3;

	function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
		abs_diff = (a >= b) ? (a - b) : (b - a);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		dr_s1  <= abs_diff(s_red, q_red);
		dg_s1  <= abs_diff(s_green, q_green);
		db_s1  <= abs_diff(s_blue, q_blue);
		lbl_s1 <= s_label;
		sr_s2  <= SW'(dr_s1) * SW'(dr_s1);
		sg_s2  <= SW'(dg_s1) * SW'(dg_s1);
		sb_s2  <= SW'(db_s1) * SW'(db_s1);
		lbl_s2 <= lbl_s1;
		sum_s3 <= (SW+2)'(sr_s2) + (SW+2)'(sg_s2) + (SW+2)'(sb_s2);
		lbl_s3 <= lbl_s2;
	end

	assign out_valid = valid_s3;
	assign sq_dist   = sum_s3;
	assign label     = lbl_s3;
	assign busy      = valid_s1 | valid_s2 | valid_s3;
endmodule

// File: design/knn_rgb_classifier_core.sv
// Top level of the k-nearest-neighbor skin color classifier.
// Requests arrive on req_ch: a load appends one labelled sample to the training RAM
// and answers at once (store_full set and the sample dropped when the RAM already
// holds MAX_SAMPLES); a clear empties the store with no answer; a classify scans the
// stored samples in load order through the distance pipeline, keeps the k nearest in
// a sorted register list (equal distances keep load order) and then votes, giving
// class 1 for skin when skin votes are at least half, else class 2. k comes from the
// cfg register (0 acts as 1, values above MAX_NEIGHBORS saturate). For N stored
// samples a classify issues one RAM read per sample, waits for the RAM read and the
// distance pipeline to drain, then counts one voting neighbor per cycle. req_ch.ready
// is low during a classify.
module knn_rgb_classifier_core #(
	parameter int MAX_SAMPLES   = knn_pkg::MAX_SAMPLES_DEF,
	parameter int MAX_NEIGHBORS = knn_pkg::MAX_NEIGHBORS_DEF,
	parameter int CHANNEL_BITS  = knn_pkg::CHANNEL_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	knn_req_if.sink                   req_ch,
	knn_rsp_if.source                 rsp_ch,
	input  logic                      cfg_we,
	input  logic [knn_pkg::CFG_W-1:0] cfg_data
);
	localparam int CB   = CHANNEL_BITS;
	localparam int DW   = 2 * CB + 2;                       // distance width
	localparam int AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CNTW = $clog2(MAX_SAMPLES + 1);
	localparam int KW   = $clog2(MAX_NEIGHBORS + 1);
	localparam int IW   = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
	localparam int RW   = 3 * CB + 1;                       // RAM word: r, g, b, label

	knn_pkg::state_t state_q, state_d;

	logic [knn_pkg::CFG_W-1:0] neighbor_count_q;
	logic [CNTW-1:0]           count_q;
	logic [CNTW-1:0]           scan_q;
	logic [KW-1:0]             k_q, filled_q, vidx_q, skin_q;
	logic [CB-1:0]             qr_q, qg_q, qb_q;
	logic                      rd_v_s1;

	logic [DW-1:0] best_d_q   [MAX_NEIGHBORS];
	logic          best_lbl_q [MAX_NEIGHBORS];
	logic [DW-1:0] best_d_n   [MAX_NEIGHBORS];
	logic          best_lbl_n [MAX_NEIGHBORS];
	logic [MAX_NEIGHBORS-1:0] lt;

	logic                        out_valid_q;
	logic [knn_pkg::CLASS_W-1:0] out_class_q;
	logic                        out_full_q;

	// decoded request
	logic          req_fire, is_load, is_query, is_clear, store_is_full;
	logic [CB-1:0] in_r, in_g, in_b;
	logic [KW-1:0] k_eff;

	// sequencer outputs
	logic scan_issue, scan_end, vote_step, vote_end, slot_free;

	// RAM and distance unit
	logic            ram_we;
	logic [AW-1:0]   ram_raddr;
	logic [RW-1:0]   ram_rdata;
	logic            d_valid, d_label, d_busy;
	logic [DW-1:0]   d_dist;

	assign slot_free     = !out_valid_q || rsp_ch.ready;
	assign req_ch.ready  = (state_q == knn_pkg::ST_IDLE) && slot_free;
	assign req_fire      = req_ch.valid && req_ch.ready;
	assign is_load       = req_fire && (req_ch.req_type == knn_pkg::REQ_LOAD);
	assign is_query      = req_fire && (req_ch.req_type == knn_pkg::REQ_CLASSIFY);
	assign is_clear      = req_fire && (req_ch.req_type == knn_pkg::REQ_CLEAR);
	assign store_is_full = (32'(count_q) >= MAX_SAMPLES);

	// low CHANNEL_BITS bits of each field are used
	assign in_r = CB'({16'd0, req_ch.red});
	assign in_g = CB'({16'd0, req_ch.green});
	assign in_b = CB'({16'd0, req_ch.blue});

	always_comb begin
		if (neighbor_count_q == '0) begin
			k_eff = KW'(1);
		end else if (32'(neighbor_count_q) > MAX_NEIGHBORS) begin
			k_eff = KW'(MAX_NEIGHBORS);
		end else begin
			k_eff = KW'(neighbor_count_q);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			knn_pkg::ST_IDLE:  if (is_query) state_d = knn_pkg::ST_SCAN;
			knn_pkg::ST_SCAN:  if (scan_end) state_d = knn_pkg::ST_DRAIN;
			knn_pkg::ST_DRAIN: if (!rd_v_s1 && !d_busy) state_d = knn_pkg::ST_VOTE;
			knn_pkg::ST_VOTE:  if (vote_end) state_d = knn_pkg::ST_DONE;
			knn_pkg::ST_DONE:  if (slot_free) state_d = knn_pkg::ST_IDLE;
			default:           state_d = knn_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		scan_issue = 1'b0;
		scan_end   = 1'b0;
		vote_step  = 1'b0;
		vote_end   = 1'b0;
		unique case (state_q)
			knn_pkg::ST_SCAN: begin
				scan_end   = (scan_q == count_q);
				scan_issue = !scan_end;
			end
			knn_pkg::ST_VOTE: begin
				vote_end  = (vidx_q == filled_q);
				vote_step = !vote_end;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= knn_pkg::ST_IDLE;
			neighbor_count_q <= knn_pkg::NEIGHBOR_RESET;
			count_q          <= '0;
			rd_v_s1          <= 1'b0;
			out_valid_q      <= 1'b0;
			filled_q         <= '0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= scan_issue;
			if (cfg_we) begin
				neighbor_count_q <= cfg_data;
			end
			if (is_clear) begin
				count_q <= '0;
			end else if (is_load && !store_is_full) begin
				count_q <= count_q + 1'b1;
			end
			if (is_query) begin
				filled_q <= '0;
			end else if (d_valid && (filled_q < k_q)) begin
				filled_q <= filled_q + 1'b1;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (is_load || (state_q == knn_pkg::ST_DONE && slot_free)) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (is_query) begin
			qr_q   <= in_r;
			qg_q   <= in_g;
			qb_q   <= in_b;
			k_q    <= k_eff;
			scan_q <= '0;
			vidx_q <= '0;
			skin_q <= '0;
		end
		if (scan_issue) begin
			scan_q <= scan_q + 1'b1;
		end
		if (vote_step) begin
			vidx_q <= vidx_q + 1'b1;
			skin_q <= skin_q + KW'(best_lbl_q[vidx_q[IW-1:0]]);
		end
		if (d_valid) begin
			best_d_q   <= best_d_n;
			best_lbl_q <= best_lbl_n;
		end
		if (is_load) begin
			out_class_q <= knn_pkg::CLASS_NONE;
			out_full_q  <= store_is_full;
		end else if (state_q == knn_pkg::ST_DONE && slot_free) begin
			// skin wins ties: 2 * skin >= votes
			out_class_q <= ({1'b0, skin_q, 1'b0} >= {2'b00, filled_q}) ?
				knn_pkg::CLASS_SKIN : knn_pkg::CLASS_NONSKIN;
			out_full_q  <= 1'b0;
		end
	end

	// sorted insert: empty slots act as infinite distance, equals stay ahead
	for (genvar j = 0; j < MAX_NEIGHBORS; j++) begin : g_ins
		assign lt[j] = (KW'(j) < k_q) && ((KW'(j) >= filled_q) || (d_dist < best_d_q[j]));
		if (j == 0) begin : g_head
			always_comb begin
				best_d_n[j]   = lt[j] ? d_dist  : best_d_q[j];
				best_lbl_n[j] = lt[j] ? d_label : best_lbl_q[j];
			end
		end else begin : g_body
			always_comb begin
				if (lt[j] && !lt[j-1]) begin
					best_d_n[j]   = d_dist;
					best_lbl_n[j] = d_label;
				end else if (lt[j]) begin
					best_d_n[j]   = best_d_q[j-1];
					best_lbl_n[j] = best_lbl_q[j-1];
				end else begin
					best_d_n[j]   = best_d_q[j];
					best_lbl_n[j] = best_lbl_q[j];
				end
			end
		end
	end

	assign ram_we    = is_load && !store_is_full;
	assign ram_raddr = scan_q[AW-1:0];

	knn_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_SAMPLES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata ({in_r, in_g, in_b, req_ch.skin_label}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	knn_dist #(
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rd_v_s1),
		.s_red     (ram_rdata[3*CB:2*CB+1]),
		.s_green   (ram_rdata[2*CB:CB+1]),
		.s_blue    (ram_rdata[CB:1]),
		.s_label   (ram_rdata[0]),
		.q_red     (qr_q),
		.q_green   (qg_q),
		.q_blue    (qb_q),
		.out_valid (d_valid),
		.sq_dist   (d_dist),
		.label     (d_label),
		.busy      (d_busy)
	);

	assign rsp_ch.valid           = out_valid_q;
	assign rsp_ch.predicted_class = out_class_q;
	assign rsp_ch.store_full      = out_full_q;
endmodule
